FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is high.
`define GDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define GDS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/gds_pkg.sv
package gds_pkg;

   // Command codes carried in the op field.
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_FWD  = 2'd1;
   localparam logic [1:0] OP_BACK = 2'd2;

   localparam logic [13:0] YEAR_MAX   = 14'd9999;
   localparam logic [13:0] RESET_YEAR = 14'd1900;
   localparam logic [3:0]  MONTH_DEC  = 4'd12;
   localparam logic [4:0]  DAY_DEC31  = 5'd31;

   // Multiplicative inverse of 25 modulo 2^14 and the matching bound:
   // y is a multiple of 25 exactly when (y * 7209) mod 2^14 <= 16383 / 25.
   localparam logic [13:0] INV25       = 14'd7209;
   localparam logic [13:0] DIV25_LIMIT = 14'd655;

   typedef struct packed {
      logic [1:0]  op;
      logic [4:0]  load_day;
      logic [3:0]  load_month;
      logic [13:0] load_year;
   } req_type;

   typedef struct packed {
      logic [4:0]  cur_day;
      logic [3:0]  cur_month;
      logic [13:0] cur_year;
      logic [8:0]  day_of_year;
      logic        leap_year;
      logic        error;
   } rsp_type;

   // Gregorian rule: multiple of 4 and not of 100, or a multiple of 400.
   function automatic logic is_leap(input logic [13:0] year);
      logic [27:0] prod;
      logic        div25;
      logic        div100;
      logic        div400;
      prod   = {14'd0, year} * {14'd0, INV25};
      div25  = (prod[13:0] <= DIV25_LIMIT);
      div100 = div25 && (year[1:0] == 2'd0);
      div400 = div25 && (year[3:0] == 4'd0);
      return ((year[1:0] == 2'd0) && !div100) || div400;
   endfunction

   // Length of a month; zero for a month code outside 1..12.
   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd2:                          len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:       len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
         4'd10, 4'd12:                  len = 5'd31;
         default:                       len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in the year before the first of a month (common year).
   function automatic logic [8:0] month_start(input logic [3:0] month);
      logic [8:0] start;
      unique case (month)
         4'd2:    start = 9'd31;
         4'd3:    start = 9'd59;
         4'd4:    start = 9'd90;
         4'd5:    start = 9'd120;
         4'd6:    start = 9'd151;
         4'd7:    start = 9'd181;
         4'd8:    start = 9'd212;
         4'd9:    start = 9'd243;
         4'd10:   start = 9'd273;
         4'd11:   start = 9'd304;
         4'd12:   start = 9'd334;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

FILE: hdl/gds_step.sv
module gds_step
   import gds_pkg::*;
(
   input  req_type cmd,
   input  rsp_type cur,
   output rsp_type nxt
);

   logic [4:0]  cur_dim;
   logic [4:0]  prev_dim;
   logic [3:0]  prev_month;
   logic        load_leap;
   logic [4:0]  load_dim;
   logic        load_ok;
   logic [13:0] step_year;
   logic        step_leap;
   logic [4:0]  new_day;
   logic [3:0]  new_month;
   logic [13:0] new_year;
   logic        new_leap;
   logic        new_err;
   logic [8:0]  new_doy;

   // Month lengths around the held date use the stored leap flag.
   assign cur_dim    = days_in(cur.cur_month, cur.leap_year);
   assign prev_month = cur.cur_month - 4'd1;
   assign prev_dim   = days_in(prev_month, cur.leap_year);

   // A load must name a real date in range.
   assign load_leap = is_leap(cmd.load_year);
   assign load_dim  = days_in(cmd.load_month, load_leap);
   assign load_ok   = (cmd.load_year <= YEAR_MAX) && (load_dim != 5'd0) &&
                      (cmd.load_day != 5'd0) && (cmd.load_day <= load_dim);

   // Year on the far side of a year boundary, and its leap flag.
   assign step_year = (cmd.op == OP_FWD) ? cur.cur_year + 14'd1 : cur.cur_year - 14'd1;
   assign step_leap = is_leap(step_year);

   // Next date, with the held date kept on any refusal.
   always_comb begin
      new_day   = cur.cur_day;
      new_month = cur.cur_month;
      new_year  = cur.cur_year;
      new_leap  = cur.leap_year;
      new_err   = 1'b0;
      unique case (cmd.op)
         OP_LOAD: begin
            if (load_ok) begin
               new_day   = cmd.load_day;
               new_month = cmd.load_month;
               new_year  = cmd.load_year;
               new_leap  = load_leap;
            end else begin
               new_err = 1'b1;
            end
         end
         OP_FWD: begin
            priority if (cur.cur_day < cur_dim) begin
               new_day = cur.cur_day + 5'd1;
            end else if (cur.cur_month < MONTH_DEC) begin
               new_day   = 5'd1;
               new_month = cur.cur_month + 4'd1;
            end else if (cur.cur_year < YEAR_MAX) begin
               new_day   = 5'd1;
               new_month = 4'd1;
               new_year  = step_year;
               new_leap  = step_leap;
            end else begin
               new_err = 1'b1;
            end
         end
         OP_BACK: begin
            priority if (cur.cur_day > 5'd1) begin
               new_day = cur.cur_day - 5'd1;
            end else if (cur.cur_month > 4'd1) begin
               new_month = prev_month;
               new_day   = prev_dim;
            end else if (cur.cur_year != 14'd0) begin
               new_day   = DAY_DEC31;
               new_month = MONTH_DEC;
               new_year  = step_year;
               new_leap  = step_leap;
            end else begin
               new_err = 1'b1;
            end
         end
         default: begin
            new_err = 1'b1;
         end
      endcase
   end

   // Ordinal day: table start of the month, plus the leap day after February.
   assign new_doy = month_start(new_month) + {4'd0, new_day} +
                    {8'd0, (new_leap && (new_month > 4'd2))};

   assign nxt.cur_day     = new_day;
   assign nxt.cur_month   = new_month;
   assign nxt.cur_year    = new_year;
   assign nxt.day_of_year = new_doy;
   assign nxt.leap_year   = new_leap;
   assign nxt.error       = new_err;

endmodule

FILE: hdl/gregorian_date_step_unit.sv
// Gregorian date counter: load, step forward or step back one day per command word.
// A request is held in the input register, then one pass of calendar logic writes the
// response register, which drives the response.
// Throughput: one command word per cycle while the receiver keeps up; a stalled response
// lets one more word into the input register, then the request side stalls.
// Synchronous active-high reset empties both registers and sets the date to 1900-01-01.
module gregorian_date_step_unit
   import gds_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   req_type in_data_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   rsp_type step_data;
   logic    advance;
   logic    req_take;

   // The response register doubles as the held date.
   gds_step u_step (
      .cmd (in_data_ff),
      .cur (rsp_data_ff),
      .nxt (step_data)
   );

   // A command moves on once the response register is free or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_data_in  = req_take ? req_data : in_data_ff;
      in_valid_in = req_take || (in_valid_ff && !advance);
      rsp_data_in = advance ? step_data : rsp_data_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         rsp_data_ff.cur_day      <= 5'd1;
         rsp_data_ff.cur_month    <= 4'd1;
         rsp_data_ff.cur_year     <= RESET_YEAR;
         rsp_data_ff.day_of_year  <= 9'd1;
         rsp_data_ff.leap_year    <= 1'b0;
         rsp_data_ff.error        <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   // Command payload needs no reset.
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/gds_checker.sv
`include "assert_macros.svh"

module gds_checker
   import gds_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled response word holds its value.
   `GDS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response word changed while stalled")

   // Reset leaves no response pending.
   `GDS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid right after reset")

   // Reported dates always hold a month in 1..12 and a day in 1..31.
   `GDS_ASSERT(a_date_range, clock, reset, rsp_valid |-> (rsp_data.cur_month >= 4'd1) && (rsp_data.cur_month <= 4'd12) && (rsp_data.cur_day >= 5'd1) && (rsp_data.cur_day <= 5'd31), "response date out of range")

   // In January the ordinal day equals the day of month.
   `GDS_ASSERT(a_jan_doy, clock, reset, rsp_valid && (rsp_data.cur_month == 4'd1) |-> rsp_data.day_of_year == {4'd0, rsp_data.cur_day}, "January ordinal day mismatch")

   // While the response register is free or being drained, a new command is taken at once.
   `GDS_ASSERT(a_ready_idle, clock, reset, (!rsp_valid || rsp_ready) |-> req_ready, "request refused while the pipe can move")

endmodule

bind gregorian_date_step_unit gds_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
